// ===== hw/rtl/lsc_pkg.sv =====
// Lottery scheduler core: shared request/result types, command codes and
// the controller <-> datapath command/status structs. No dependencies.
package lsc_pkg;

  localparam int CMD_W  = 2;
  localparam int SLOT_W = 4;
  localparam int TV_W   = 16;
  localparam int RND_W  = 32;
  localparam int TOT_W  = 20;
  localparam int DCNT_W = $clog2(RND_W);

  localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_XFER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAW = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] other_slot;
    logic [TV_W-1:0]   ticket_value;
    logic              runnable;
    logic [RND_W-1:0]  random_draw;
  } in_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] winner_slot;
    logic              winner_found;
    logic [TV_W-1:0]   moved_tickets;
    logic [TOT_W-1:0]  total_tickets;
  } out_res_t;

  typedef struct packed {
    logic load_req;
    logic wr_set;
    logic xcalc;
    logic wr_src;
    logic wr_dst;
    logic walk_init;
    logic walk_step;
    logic div_init;
    logic div_step;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic xfer_ok;
    logic walk_last;
    logic div_last;
    logic total_zero;
    logic hit;
  } dp_stat_t;

endpackage

// ===== hw/rtl/lottery_scheduler_core.sv =====
// Lottery scheduler core, top level: controller plus datapath.
// Depends on lsc_pkg, lsc_ctrl, lsc_dp (and lsc_ram through lsc_dp).
//
// Usage:
//   Requests enter on in_valid/in_stall/in_data, one command each: set a slot,
//   transfer tickets between two slots, or draw a winner. Every request gives
//   exactly one result on out_valid/out_stall/out_data.
//   A request is taken when valid is high and stall is low at a clock edge.
//   One request is worked at a time; in_stall is high from acceptance until
//   its result has been loaded into the output register.
//   A set writes its slot when the slot is in range; a transfer reads both
//   slots and writes source then destination, or writes nothing when the
//   slots are invalid or equal; an unused command goes straight to the output.
//   A draw is a sum walk over the slot RAM, a bit-serial remainder, then a
//   scan walk that stops at the winner. A zero-ticket draw skips remainder and scan.
//   The output register decouples the sides: the next request is accepted
//   while a result still waits, but its result is held back until the
//   receiver drops out_stall. A stalled result stays unchanged.
//   Reset (rst_n low, synchronous) empties the table: every slot reads as
//   zero tickets and not runnable, and no result is pending.
module lottery_scheduler_core
  import lsc_pkg::*;
#(
  parameter int NUM_SLOTS   = 16,
  parameter int TICKET_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  lsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  lsc_dp #(
    .NUM_SLOTS   (NUM_SLOTS),
    .TICKET_BITS (TICKET_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== hw/rtl/lsc_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module lsc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    ra_addr,
  input  logic [AW-1:0]    rb_addr,
  output logic [WIDTH-1:0] ra_data,
  output logic [WIDTH-1:0] rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// ===== hw/rtl/lsc_ctrl.sv =====
// Lottery scheduler controller: sequences set, transfer and draw requests.
// Depends on lsc_pkg; drives the datapath through ctl_cmd_t / dp_stat_t.
module lsc_ctrl
  import lsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output ctl_cmd_t         cmd,
  input  dp_stat_t         stat
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETW  = 4'd1;
  localparam logic [3:0] S_XRD   = 4'd2;
  localparam logic [3:0] S_XCALC = 4'd3;
  localparam logic [3:0] S_XWS   = 4'd4;
  localparam logic [3:0] S_XWD   = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_DCHK  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_SCAN  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          case (in_cmd)
            CMD_SET:  state_nxt = S_SETW;
            CMD_XFER: state_nxt = S_XRD;
            CMD_DRAW: state_nxt = S_SUM;
            default:  state_nxt = S_OUT;
          endcase
        end
      end
      S_SETW: begin
        cmd.wr_set = 1'b1;
        state_nxt  = S_OUT;
      end
      S_XRD: begin
        state_nxt = stat.xfer_ok ? S_XCALC : S_OUT;
      end
      S_XCALC: begin
        cmd.xcalc = 1'b1;
        state_nxt = S_XWS;
      end
      S_XWS: begin
        cmd.wr_src = 1'b1;
        state_nxt  = S_XWD;
      end
      S_XWD: begin
        cmd.wr_dst = 1'b1;
        state_nxt  = S_OUT;
      end
      S_SUM: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_nxt = S_DCHK;
        end
      end
      S_DCHK: begin
        if (stat.total_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_init  = 1'b1;
          cmd.walk_init = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.walk_step = 1'b1;
        if (stat.hit || stat.walk_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_vld_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_vld_r;

  // a new result never overwrites one still waiting on a stalled receiver
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !cmd.load_out)
    else $error("result overwritten while stalled");

  // the remainder loop runs to completion before the scan starts
  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !stat.div_last) |=> (state_r == S_DIV))
    else $error("remainder loop left early");

endmodule

// ===== hw/rtl/lsc_dp.sv =====
// Lottery scheduler datapath: slot table (RAM plus valid bits), transfer
// arithmetic, ticket sum, bit-serial remainder and winner scan.
// Depends on lsc_pkg and lsc_ram.
module lsc_dp
  import lsc_pkg::*;
#(
  parameter int NUM_SLOTS   = 16,
  parameter int TICKET_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_data,
  input  ctl_cmd_t cmd,
  output dp_stat_t stat,
  output out_res_t out_data
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int SUM_W = TICKET_BITS + IDX_W;
  localparam int MV_W  = (TICKET_BITS > TV_W) ? TICKET_BITS : TV_W;
  localparam int ENT_W = TICKET_BITS + 1;

  in_req_t                req_r;
  logic [NUM_SLOTS-1:0]   vld_r;
  logic                   va_r, vb_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [DCNT_W-1:0]      dcnt_r;
  logic [RND_W-1:0]       rnd_r;
  logic [SUM_W-1:0]       total_r, rem_r, run_sum_r;
  logic [TICKET_BITS-1:0] moved_r, src_new_r, dst_new_r;
  logic                   src_run_r, dst_run_r;
  logic [IDX_W-1:0]       win_r;
  logic                   found_r;
  logic                   sum_phase_r;
  out_res_t               out_r;

  logic [IDX_W-1:0]       src_idx, dst_idx, addr_a, waddr, ent_idx;
  logic                   slot_ok, dst_ok, we;
  logic [ENT_W-1:0]       wdata, ra_data, rb_data;
  logic [TICKET_BITS-1:0] a_tk, b_tk, moved_nxt;
  logic                   a_run, b_run;
  logic [MV_W-1:0]        m_src, m_req, m_room, m_min;
  logic [SUM_W-1:0]       a_add, run_sum_nxt, rem_nxt, total_acc;
  logic [SUM_W:0]         div_t, div_d;
  logic                   hit;

  assign src_idx = IDX_W'(req_r.slot);
  assign dst_idx = IDX_W'(req_r.other_slot);
  assign slot_ok = 32'(req_r.slot) < NUM_SLOTS;
  assign dst_ok  = 32'(req_r.other_slot) < NUM_SLOTS;
  assign addr_a  = (req_r.cmd == CMD_DRAW) ? IDX_W'(cnt_r) : src_idx;
  assign ent_idx = IDX_W'(cnt_r - CNT_W'(1));

  always_comb begin
    we    = 1'b0;
    waddr = src_idx;
    wdata = {req_r.runnable, TICKET_BITS'(req_r.ticket_value)};
    if (cmd.wr_set && slot_ok) begin
      we = 1'b1;
    end else if (cmd.wr_src) begin
      we    = 1'b1;
      wdata = {src_run_r, src_new_r};
    end else if (cmd.wr_dst) begin
      we    = 1'b1;
      waddr = dst_idx;
      wdata = {dst_run_r, dst_new_r};
    end
  end

  lsc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (addr_a),
    .rb_addr (dst_idx),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  // never-written slots read as zero tickets, not runnable
  assign a_tk  = va_r ? ra_data[TICKET_BITS-1:0] : '0;
  assign a_run = va_r & ra_data[TICKET_BITS];
  assign b_tk  = vb_r ? rb_data[TICKET_BITS-1:0] : '0;
  assign b_run = vb_r & rb_data[TICKET_BITS];

  // moved = min(source, request, room left in destination)
  always_comb begin
    m_src  = MV_W'(a_tk);
    m_req  = MV_W'(req_r.ticket_value);
    m_room = MV_W'(~b_tk);
    m_min  = (m_src < m_req) ? m_src : m_req;
    if (m_room < m_min) begin
      m_min = m_room;
    end
    moved_nxt = TICKET_BITS'(m_min);
  end

  assign a_add       = a_run ? SUM_W'(a_tk) : '0;
  assign run_sum_nxt = run_sum_r + a_add;
  // winner search only in the scan walk, not in the sum walk
  assign hit = cmd.walk_step && !sum_phase_r && (cnt_r != '0) && a_run
               && (run_sum_nxt > rem_r);

  // restoring remainder, one dividend bit per cycle
  assign div_t   = {rem_r, rnd_r[RND_W-1]};
  assign div_d   = {1'b0, total_r};
  assign rem_nxt = (div_t >= div_d) ? SUM_W'(div_t - div_d) : SUM_W'(div_t);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      cnt_r   <= '0;
      dcnt_r  <= '0;
      total_r <= '0;
      moved_r <= '0;
      found_r <= 1'b0;
      win_r   <= '0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (cmd.load_req) begin
        cnt_r   <= '0;
        total_r <= '0;
        moved_r <= '0;
        found_r <= 1'b0;
        win_r   <= '0;
      end
      if (cmd.walk_init) begin
        cnt_r <= '0;
      end else if (cmd.walk_step && (cnt_r != CNT_W'(NUM_SLOTS))) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.walk_step && sum_phase_r && (cnt_r != '0)) begin
        total_r <= total_acc;
      end
      if (cmd.div_init) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      if (cmd.xcalc) begin
        moved_r <= moved_nxt;
      end
      if (hit) begin
        found_r <= 1'b1;
        win_r   <= ent_idx;
      end
    end
  end

  // sum pass: total_r accumulates while walking before the remainder loop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_phase_r <= 1'b0;
    end else if (cmd.load_req) begin
      sum_phase_r <= 1'b1;
    end else if (cmd.div_init) begin
      sum_phase_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    va_r <= (32'(addr_a) < NUM_SLOTS) ? vld_r[addr_a] : 1'b0;
    vb_r <= dst_ok ? vld_r[dst_idx] : 1'b0;
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.walk_init) begin
      run_sum_r <= '0;
    end else if (cmd.walk_step && (cnt_r != '0)) begin
      run_sum_r <= run_sum_nxt;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      rnd_r <= req_r.random_draw;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      rnd_r <= {rnd_r[RND_W-2:0], 1'b0};
    end
    if (cmd.xcalc) begin
      src_new_r <= a_tk - moved_nxt;
      dst_new_r <= b_tk + moved_nxt;
      src_run_r <= a_run;
      dst_run_r <= b_run;
    end
    if (cmd.load_out) begin
      out_r.winner_slot   <= SLOT_W'(win_r);
      out_r.winner_found  <= found_r;
      out_r.moved_tickets <= TV_W'(moved_r);
      out_r.total_tickets <= TOT_W'(total_r);
    end
  end

  // running total of runnable tickets during the sum walk
  assign total_acc = total_r + a_add;

  assign stat.xfer_ok    = slot_ok && dst_ok && (req_r.slot != req_r.other_slot);
  assign stat.walk_last  = (cnt_r == CNT_W'(NUM_SLOTS));
  assign stat.div_last   = (dcnt_r == {DCNT_W{1'b1}});
  assign stat.total_zero = (total_r == '0);
  assign stat.hit        = hit;
  assign out_data        = out_r;

  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (total_r != '0))
    else $error("winner reported with zero ticket total");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk_step && !sum_phase_r) |-> (rem_r < total_r))
    else $error("winning ticket not below total");

  a_moved_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (MV_W'(moved_r) <= MV_W'(req_r.ticket_value)))
    else $error("transfer moved more than requested");

  a_sum_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk_step && sum_phase_r && (cnt_r != '0)) |=> (total_r == $past(total_acc)))
    else $error("ticket sum did not accumulate");

endmodule
